### rtl/mid_side_stereo_width_defines.svh
// ----------------------------------------------------------------
// mid/side stereo width assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------
`ifndef MID_SIDE_STEREO_WIDTH_DEFINES_SVH
`define MID_SIDE_STEREO_WIDTH_DEFINES_SVH

// same-cycle implication
`define MSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/msw_pkg.sv
// ----------------------------------------------------------------
// mid/side stereo width package
// widths, constants, register indexes and shared types
// ----------------------------------------------------------------
package msw_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int SUM_BITS       = SAMPLE_BITS + 1;
  localparam int GAIN_FRAC      = 17;
  localparam int GAIN_BITS      = 18;
  localparam int STEP_BITS      = 20;
  localparam int PROD_BITS      = GAIN_BITS + 1 + SUM_BITS;
  localparam int WIDTH_BITS     = 16;
  localparam int WIDTH_FRAC     = 12;
  localparam int DEN_BITS       = WIDTH_BITS + 1;
  localparam int DIV_BITS       = 33;
  localparam int CNT_BITS       = $clog2(DIV_BITS);
  localparam int RAMP_SAMPLES   = 256;
  localparam int RAMP_LOG2      = $clog2(RAMP_SAMPLES);
  localparam int RAMP_BITS      = 13;
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [WIDTH_BITS-1:0] WIDTH_ONE = WIDTH_BITS'(1 << WIDTH_FRAC);
  localparam logic [GAIN_BITS-1:0]  GAIN_HALF = GAIN_BITS'(1 << (GAIN_FRAC - 1));

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_BYPASS = CFG_INDEX_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] sum;
    logic [GAIN_BITS-1:0] diff;
  } gain_t;

  typedef struct packed {
    logic busy;
    logic bypass;
  } gain_stat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clip;
  } lane_t;

endpackage

### rtl/mid_side_stereo_width.sv
// ----------------------------------------------------------------
// mid/side stereo width control
// stereo width by mid/side gains with a linear gain ramp on width writes
// ----------------------------------------------------------------
// channel  direction  handshake               payload
// pair     in         pair_valid/pair_stall    left_in, right_in
// result   out        result_valid/result_stall left_out, right_out, clipped
// cfg      in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// one pair per cycle while pair_stall is low, through three registered stages
// a width write above 1.0 runs a bit-serial divider, then the step state;
// cfg_ready and pair_stall hold through both (step only at or below 1.0)
// reset sets width 1.0, bypass off, pipeline empty
// result_stall backs up through the three registered stages into pair_stall
// ----------------------------------------------------------------
module mid_side_stereo_width (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pair_valid,
  output logic                                   pair_stall,
  input  logic signed [msw_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic signed [msw_pkg::SAMPLE_BITS-1:0] right_in,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [msw_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [msw_pkg::SAMPLE_BITS-1:0] right_out,
  output logic                                   clipped,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [msw_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [msw_pkg::WIDTH_BITS-1:0]         cfg_data
);

  msw_pkg::gain_t      gain;
  msw_pkg::gain_stat_t stat;
  msw_pkg::lane_t      lane_l, lane_r;

  logic take;
  logic en1, en2, en3;

  // stage 1: sum and difference
  logic                                   v1, byp1;
  logic signed [msw_pkg::SAMPLE_BITS-1:0] l1, r1;
  logic signed [msw_pkg::SUM_BITS-1:0]    sum1, dif1;
  logic [msw_pkg::GAIN_BITS-1:0]          gs1, gd1;

  // stage 2: mid and side products
  logic                                   v2, byp2;
  logic signed [msw_pkg::SAMPLE_BITS-1:0] l2, r2;
  logic signed [msw_pkg::PROD_BITS-1:0]   mid2, side2;

  assign en3        = !result_valid || !result_stall;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign pair_stall = !en1 || stat.busy;
  assign take       = pair_valid && !pair_stall;

  msw_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .gain      (gain),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) v1 <= take;
      if (en2) v2 <= v1;
      if (en3) result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      byp1 <= stat.bypass;
      l1   <= left_in;
      r1   <= right_in;
      sum1 <= msw_pkg::SUM_BITS'(left_in) + msw_pkg::SUM_BITS'(right_in);
      dif1 <= msw_pkg::SUM_BITS'(right_in) - msw_pkg::SUM_BITS'(left_in);
      gs1  <= gain.sum;
      gd1  <= gain.diff;
    end
    if (en2) begin
      byp2  <= byp1;
      l2    <= l1;
      r2    <= r1;
      mid2  <= $signed({1'b0, gs1}) * sum1;
      side2 <= $signed({1'b0, gd1}) * dif1;
    end
    if (en3) begin
      left_out  <= lane_l.sample;
      right_out <= lane_r.sample;
      clipped   <= lane_l.clip | lane_r.clip;
    end
  end

  msw_lane u_lane_l (
    .mid      (mid2),
    .side     (side2),
    .sub_side (1'b1),
    .bypass   (byp2),
    .raw      (l2),
    .res      (lane_l)
  );

  msw_lane u_lane_r (
    .mid      (mid2),
    .side     (side2),
    .sub_side (1'b0),
    .bypass   (byp2),
    .raw      (r2),
    .res      (lane_r)
  );

endmodule

### rtl/msw_gain.sv
// ----------------------------------------------------------------
// mid/side gain control
// config registers, target gain divider and per-word gain ramp
// ----------------------------------------------------------------
module msw_gain (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [msw_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [msw_pkg::WIDTH_BITS-1:0]         cfg_data,
  input  logic                                   take,
  output msw_pkg::gain_t                         gain,
  output msw_pkg::gain_stat_t                    stat
);

  msw_pkg::state_t state, state_next;

  logic [msw_pkg::CNT_BITS-1:0]  count;
  logic [msw_pkg::DIV_BITS-1:0]  num_s, num_d;
  logic [msw_pkg::DEN_BITS-1:0]  rem_s, rem_d, den;
  logic [msw_pkg::GAIN_BITS-1:0] sum_now, diff_now, sum_goal, diff_goal;
  logic signed [msw_pkg::STEP_BITS-1:0] sum_step, diff_step;
  logic [msw_pkg::RAMP_BITS-1:0] ramp_left;
  logic                          bypass;

  logic                          busy;
  logic                          wr, wr_width, wr_bypass;
  logic                          last;
  logic [msw_pkg::DEN_BITS-1:0]  den_next, half_next;
  logic [msw_pkg::DEN_BITS:0]    trial_s, trial_d, sub_s, sub_d;
  logic                          q_s, q_d;
  logic [msw_pkg::DEN_BITS-1:0]  rem_s_next, rem_d_next;
  logic signed [msw_pkg::STEP_BITS-1:0] sum_delta, diff_delta;
  logic signed [msw_pkg::STEP_BITS-1:0] sum_step_next, diff_step_next;
  logic [msw_pkg::STEP_BITS-1:0] sum_ramp, diff_ramp;
  msw_pkg::gain_t                use_gain;
  logic                          adv;

  assign wr        = cfg_valid && cfg_ready;
  assign wr_width  = wr && (cfg_index == msw_pkg::REG_WIDTH);
  assign wr_bypass = wr && (cfg_index == msw_pkg::REG_BYPASS);
  assign last      = (count == msw_pkg::CNT_BITS'(msw_pkg::DIV_BITS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      msw_pkg::ST_IDLE: begin
        if (wr_width) begin
          state_next = (cfg_data > msw_pkg::WIDTH_ONE) ? msw_pkg::ST_DIVIDE
                                                       : msw_pkg::ST_STEP;
        end
      end
      msw_pkg::ST_DIVIDE: begin
        if (last) state_next = msw_pkg::ST_STEP;
      end
      msw_pkg::ST_STEP:   state_next = msw_pkg::ST_IDLE;
      default:            state_next = msw_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != msw_pkg::ST_IDLE);
    cfg_ready = !busy;
  end

  // divider setup and one quotient bit per cycle
  assign den_next   = {1'b0, cfg_data} + msw_pkg::DEN_BITS'(msw_pkg::WIDTH_ONE);
  assign half_next  = den_next >> 1;
  assign trial_s    = {rem_s, num_s[msw_pkg::DIV_BITS-1]};
  assign trial_d    = {rem_d, num_d[msw_pkg::DIV_BITS-1]};
  assign sub_s      = trial_s - {1'b0, den};
  assign sub_d      = trial_d - {1'b0, den};
  assign q_s        = (trial_s >= {1'b0, den});
  assign q_d        = (trial_d >= {1'b0, den});
  assign rem_s_next = q_s ? sub_s[msw_pkg::DEN_BITS-1:0] : trial_s[msw_pkg::DEN_BITS-1:0];
  assign rem_d_next = q_d ? sub_d[msw_pkg::DEN_BITS-1:0] : trial_d[msw_pkg::DEN_BITS-1:0];

  // ramp step, truncated toward zero
  assign sum_delta  = $signed({2'b00, sum_goal}) - $signed({2'b00, sum_now});
  assign diff_delta = $signed({2'b00, diff_goal}) - $signed({2'b00, diff_now});
  assign sum_step_next = sum_delta[msw_pkg::STEP_BITS-1]
    ? (sum_delta + msw_pkg::STEP_BITS'(msw_pkg::RAMP_SAMPLES - 1)) >>> msw_pkg::RAMP_LOG2
    : sum_delta >>> msw_pkg::RAMP_LOG2;
  assign diff_step_next = diff_delta[msw_pkg::STEP_BITS-1]
    ? (diff_delta + msw_pkg::STEP_BITS'(msw_pkg::RAMP_SAMPLES - 1)) >>> msw_pkg::RAMP_LOG2
    : diff_delta >>> msw_pkg::RAMP_LOG2;

  // gains for the word being taken
  assign sum_ramp  = {2'b00, sum_now} + sum_step;
  assign diff_ramp = {2'b00, diff_now} + diff_step;

  always_comb begin
    priority if (ramp_left == msw_pkg::RAMP_BITS'(1)) begin
      use_gain.sum  = sum_goal;
      use_gain.diff = diff_goal;
    end else if (ramp_left != '0) begin
      use_gain.sum  = sum_ramp[msw_pkg::GAIN_BITS-1:0];
      use_gain.diff = diff_ramp[msw_pkg::GAIN_BITS-1:0];
    end else begin
      use_gain.sum  = sum_now;
      use_gain.diff = diff_now;
    end
  end

  assign adv  = take && !bypass;
  assign gain = use_gain;
  assign stat = '{busy: busy, bypass: bypass};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= msw_pkg::ST_IDLE;
      count     <= '0;
      sum_now   <= msw_pkg::GAIN_HALF;
      diff_now  <= msw_pkg::GAIN_HALF;
      sum_goal  <= msw_pkg::GAIN_HALF;
      diff_goal <= msw_pkg::GAIN_HALF;
      sum_step  <= '0;
      diff_step <= '0;
      ramp_left <= '0;
      bypass    <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_bypass) bypass <= cfg_data[0];
      unique case (state)
        msw_pkg::ST_IDLE: begin
          if (wr_width) begin
            count <= '0;
            den   <= den_next;
            rem_s <= '0;
            rem_d <= '0;
            num_s <= (msw_pkg::DIV_BITS'(msw_pkg::WIDTH_ONE) << msw_pkg::GAIN_FRAC)
                     + msw_pkg::DIV_BITS'(half_next);
            num_d <= (msw_pkg::DIV_BITS'(cfg_data) << msw_pkg::GAIN_FRAC)
                     + msw_pkg::DIV_BITS'(half_next);
            if (cfg_data <= msw_pkg::WIDTH_ONE) begin
              sum_goal  <= msw_pkg::GAIN_HALF;
              diff_goal <= msw_pkg::GAIN_BITS'(
                {cfg_data, 4'b0000} >> (msw_pkg::WIDTH_FRAC + 5 - msw_pkg::GAIN_FRAC));
            end
          end
          if (adv) begin
            sum_now  <= use_gain.sum;
            diff_now <= use_gain.diff;
            if (ramp_left != '0) ramp_left <= ramp_left - 1'b1;
          end
        end
        msw_pkg::ST_DIVIDE: begin
          count <= count + 1'b1;
          rem_s <= rem_s_next;
          rem_d <= rem_d_next;
          num_s <= {num_s[msw_pkg::DIV_BITS-2:0], q_s};
          num_d <= {num_d[msw_pkg::DIV_BITS-2:0], q_d};
          if (last) begin
            sum_goal  <= {num_s[msw_pkg::GAIN_BITS-2:0], q_s};
            diff_goal <= {num_d[msw_pkg::GAIN_BITS-2:0], q_d};
          end
        end
        msw_pkg::ST_STEP: begin
          sum_step  <= sum_step_next;
          diff_step <= diff_step_next;
          ramp_left <= msw_pkg::RAMP_BITS'(msw_pkg::RAMP_SAMPLES);
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/msw_lane.sv
// ----------------------------------------------------------------
// mid/side output lane; passes the raw sample in bypass
// combines mid and side for one channel, rounds and saturates
// ----------------------------------------------------------------
module msw_lane (
  input  logic signed [msw_pkg::PROD_BITS-1:0]   mid,
  input  logic signed [msw_pkg::PROD_BITS-1:0]   side,
  input  logic                                   sub_side,
  input  logic                                   bypass,
  input  logic signed [msw_pkg::SAMPLE_BITS-1:0] raw,
  output msw_pkg::lane_t                         res
);

  localparam int ACC_BITS = msw_pkg::PROD_BITS + 1;
  localparam int RND_BITS = ACC_BITS - msw_pkg::GAIN_FRAC;

  logic signed [ACC_BITS-1:0] acc, biased;
  logic signed [RND_BITS-1:0] rnd;

  always_comb begin
    if (sub_side) begin
      acc = ACC_BITS'(mid) - ACC_BITS'(side);
    end else begin
      acc = ACC_BITS'(mid) + ACC_BITS'(side);
    end
    biased = acc + ACC_BITS'(1 << (msw_pkg::GAIN_FRAC - 1));
    rnd    = RND_BITS'(biased >>> msw_pkg::GAIN_FRAC);
    priority if (bypass) begin
      res.sample = raw;
      res.clip   = 1'b0;
    end else if (rnd > RND_BITS'(msw_pkg::SAMPLE_MAX)) begin
      res.sample = msw_pkg::SAMPLE_MAX;
      res.clip   = 1'b1;
    end else if (rnd < RND_BITS'(msw_pkg::SAMPLE_MIN)) begin
      res.sample = msw_pkg::SAMPLE_MIN;
      res.clip   = 1'b1;
    end else begin
      res.sample = rnd[msw_pkg::SAMPLE_BITS-1:0];
      res.clip   = 1'b0;
    end
  end

endmodule

### rtl/msw_checker.sv
// ----------------------------------------------------------------
// mid/side stereo width port checker
// properties on the top level ports, bound to the top level
// ----------------------------------------------------------------
`include "mid_side_stereo_width_defines.svh"

module msw_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   pair_stall,
  input logic                                   result_valid,
  input logic                                   result_stall,
  input logic signed [msw_pkg::SAMPLE_BITS-1:0] left_out,
  input logic signed [msw_pkg::SAMPLE_BITS-1:0] right_out,
  input logic                                   clipped,
  input logic                                   cfg_valid,
  input logic                                   cfg_ready,
  input logic [msw_pkg::CFG_INDEX_BITS-1:0]     cfg_index
);

  logic width_wr;
  logic left_rail, right_rail;

  assign width_wr   = cfg_valid && cfg_ready && (cfg_index == msw_pkg::REG_WIDTH);
  assign left_rail  = (left_out == msw_pkg::SAMPLE_MAX) || (left_out == msw_pkg::SAMPLE_MIN);
  assign right_rail = (right_out == msw_pkg::SAMPLE_MAX) || (right_out == msw_pkg::SAMPLE_MIN);

  // stalled result word holds
  `MSW_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(left_out) && $stable(right_out) && $stable(clipped), "stalled result word changed")

  // gain update in progress blocks sample words
  `MSW_ASSERT_NOW(a_busy_stalls, !cfg_ready, pair_stall, "pair taken during gain update")

  // a width write always starts a gain update
  `MSW_ASSERT_NEXT(a_width_busy, width_wr, !cfg_ready, "width write did not start gain update")

  // a clip flag means a sample sits on a rail
  `MSW_ASSERT_NOW(a_clip_rail, result_valid && clipped, left_rail || right_rail, "clip flag without saturated sample")

endmodule

bind mid_side_stereo_width msw_checker u_msw_checker (.*);

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------
// mid/side stereo width testbench
// drives sample pairs and width/bypass writes into the block, predicts
// every output word from its own gain and ramp state, and checks each
// result in order against the prediction under random idling and stalls
// ----------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PAIRS = 600;
  localparam logic [msw_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = msw_pkg::REG_BYPASS + 1'b1;
  localparam int REG_SPARE_HI = (1 << msw_pkg::CFG_INDEX_BITS) - 1;

  typedef logic signed [msw_pkg::SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    clip;
  } stereo_out_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               pair_valid = 1'b0;
  logic                               pair_stall;
  sample_t                            left_in = '0;
  sample_t                            right_in = '0;
  logic                               result_valid;
  logic                               result_stall = 1'b0;
  sample_t                            left_out;
  sample_t                            right_out;
  logic                               clipped;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [msw_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [msw_pkg::WIDTH_BITS-1:0]     cfg_data = '0;

  stereo_pair_t pending_pairs_q[$];
  stereo_out_t  expected_out_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  // gain state of the block
  logic [msw_pkg::GAIN_BITS-1:0] sum_gain;
  logic [msw_pkg::GAIN_BITS-1:0] diff_gain;
  logic [msw_pkg::GAIN_BITS-1:0] sum_goal;
  logic [msw_pkg::GAIN_BITS-1:0] diff_goal;
  int                            sum_step;
  int                            diff_step;
  int                            ramp_count;
  logic                          bypass_on;

  mid_side_stereo_width uut (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .left_in      (left_in),
    .right_in     (right_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .left_out     (left_out),
    .right_out    (right_out),
    .clipped      (clipped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void set_gain_goals(logic [msw_pkg::WIDTH_BITS-1:0] w);
    longint den;
    if (w > msw_pkg::WIDTH_ONE) begin
      den = longint'(msw_pkg::WIDTH_ONE) + longint'(w);
      sum_goal = msw_pkg::GAIN_BITS'(
        ((longint'(msw_pkg::WIDTH_ONE) << msw_pkg::GAIN_FRAC) + den / 2) / den);
      diff_goal = msw_pkg::GAIN_BITS'(((longint'(w) << msw_pkg::GAIN_FRAC) + den / 2) / den);
    end else begin
      sum_goal = msw_pkg::GAIN_HALF;
      diff_goal = msw_pkg::GAIN_BITS'(
        longint'(w) << (msw_pkg::GAIN_FRAC - msw_pkg::WIDTH_FRAC - 1));
    end
  endfunction

  function automatic void apply_reg(logic [msw_pkg::CFG_INDEX_BITS-1:0] idx,
                                    logic [msw_pkg::WIDTH_BITS-1:0] data);
    if (idx == msw_pkg::REG_WIDTH) begin
      set_gain_goals(data);
      sum_step = (int'(sum_goal) - int'(sum_gain)) / msw_pkg::RAMP_SAMPLES;
      diff_step = (int'(diff_goal) - int'(diff_gain)) / msw_pkg::RAMP_SAMPLES;
      ramp_count = msw_pkg::RAMP_SAMPLES;
    end else if (idx == msw_pkg::REG_BYPASS) begin
      bypass_on = data[0];
    end
  endfunction

  function automatic sample_t round_clamp(longint acc, inout logic clip);
    longint y;
    y = (acc + (longint'(1) << (msw_pkg::GAIN_FRAC - 1))) >>> msw_pkg::GAIN_FRAC;
    if (y > longint'(msw_pkg::SAMPLE_MAX)) begin
      clip = 1'b1;
      return msw_pkg::SAMPLE_MAX;
    end
    if (y < longint'(msw_pkg::SAMPLE_MIN)) begin
      clip = 1'b1;
      return msw_pkg::SAMPLE_MIN;
    end
    return sample_t'(y);
  endfunction

  function automatic stereo_out_t widen_pair(sample_t l, sample_t r);
    stereo_out_t res;
    longint ls;
    longint rs;
    longint mid;
    longint side;
    logic clip;
    if (bypass_on) begin
      res.left = l;
      res.right = r;
      res.clip = 1'b0;
      return res;
    end
    if (ramp_count != 0) begin
      ramp_count--;
      if (ramp_count != 0) begin
        sum_gain = msw_pkg::GAIN_BITS'(int'(sum_gain) + sum_step);
        diff_gain = msw_pkg::GAIN_BITS'(int'(diff_gain) + diff_step);
      end else begin
        sum_gain = sum_goal;
        diff_gain = diff_goal;
      end
    end
    ls = l;
    rs = r;
    mid = longint'(sum_gain) * (ls + rs);
    side = longint'(diff_gain) * (rs - ls);
    clip = 1'b0;
    res.left = round_clamp(mid - side, clip);
    res.right = round_clamp(mid + side, clip);
    res.clip = clip;
    return res;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(4))
      0: return sample_t'($signed($urandom) >>> $urandom_range(8, 31));
      1: return $urandom_range(1) ? msw_pkg::SAMPLE_MAX : msw_pkg::SAMPLE_MIN;
      2: return sample_t'($signed($urandom) >>> $urandom_range(8, 14));
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [msw_pkg::WIDTH_BITS-1:0] pick_width();
    case ($urandom_range(5))
      0: return '0;
      1: return msw_pkg::WIDTH_ONE;
      2: return msw_pkg::WIDTH_ONE + 1'b1;
      3: return '1;
      4: return msw_pkg::WIDTH_BITS'($urandom_range(msw_pkg::WIDTH_ONE));
      default: return msw_pkg::WIDTH_BITS'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin : pair_driver
    stereo_pair_t nxt;
    if (rst) begin
      pair_valid <= 1'b0;
    end else begin
      if (pair_valid && !pair_stall) begin
        expected_out_q.push_back(widen_pair(left_in, right_in));
      end
      if (!pair_valid || !pair_stall) begin
        if (pending_pairs_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_pairs_q.pop_front();
          pair_valid <= 1'b1;
          left_in <= nxt.left;
          right_in <= nxt.right;
        end else begin
          pair_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    stereo_out_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_out_q.size() == 0) begin
          if (errors < MAX_REPORTS) begin
            $display("unexpected word: left %0d right %0d clip %0b",
                     left_out, right_out, clipped);
          end
          errors++;
        end else begin
          want = expected_out_q.pop_front();
          if (left_out !== want.left || right_out !== want.right ||
              clipped !== want.clip) begin
            if (errors < MAX_REPORTS) begin
              $display("mismatch: left %0d/%0d right %0d/%0d clip %0b/%0b (exp/got)",
                       want.left, left_out, want.right, right_out, want.clip, clipped);
            end
            errors++;
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL mid_side_stereo_width");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_pairs_q.size() != 0 || pair_valid || expected_out_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [msw_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [msw_pkg::WIDTH_BITS-1:0] data);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pair(sample_t l, sample_t r);
    stereo_pair_t p;
    p.left = l;
    p.right = r;
    pending_pairs_q.push_back(p);
  endtask

  task automatic queue_extremes(int n);
    sample_t ext_l[6];
    sample_t ext_r[6];
    ext_l = '{msw_pkg::SAMPLE_MAX, msw_pkg::SAMPLE_MIN, msw_pkg::SAMPLE_MAX,
              msw_pkg::SAMPLE_MIN, '0, sample_t'(-1)};
    ext_r = '{msw_pkg::SAMPLE_MAX, msw_pkg::SAMPLE_MIN, msw_pkg::SAMPLE_MIN,
              msw_pkg::SAMPLE_MAX, '0, sample_t'(1)};
    for (int i = 0; i < n; i++) begin
      queue_pair(ext_l[i], ext_r[i]);
    end
  endtask

  task automatic queue_random(int n);
    sample_t l;
    for (int i = 0; i < n; i++) begin
      l = pick_sample();
      case ($urandom_range(5))
        0: queue_pair(l, l);
        1: queue_pair(l, -l);
        default: queue_pair(l, pick_sample());
      endcase
    end
  endtask

  initial begin : stimulus
    int rand_pairs;
    int phase;
    int n;
    set_gain_goals(msw_pkg::WIDTH_ONE);
    sum_gain = sum_goal;
    diff_gain = diff_goal;
    sum_step = 0;
    diff_step = 0;
    ramp_count = 0;
    bypass_on = 1'b0;
    send_idle_pct = 19;
    recv_stall_pct = 52;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // unity width passes the pair through the mid/side matrix
    queue_extremes(6);
    // widest setting, samples taken during the ramp
    write_reg(msw_pkg::REG_WIDTH, '1);
    queue_extremes(6);
    // same value again restarts the ramp
    write_reg(msw_pkg::REG_WIDTH, '1);
    queue_random(2);
    // collapse to mono from the middle of a ramp
    write_reg(msw_pkg::REG_WIDTH, '0);
    queue_random(3);
    // bypass freezes the ramp, even across a width write
    write_reg(msw_pkg::REG_BYPASS, 16'd1);
    queue_extremes(4);
    write_reg(msw_pkg::REG_WIDTH, msw_pkg::WIDTH_ONE + 1'b1);
    write_reg(msw_pkg::REG_BYPASS, 16'd0);
    queue_random(2);
    // write to an unused index has no effect
    write_reg(msw_pkg::CFG_INDEX_BITS'(REG_SPARE_HI), '1);
    queue_random(2);

    rand_pairs = 0;
    phase = 0;
    while (rand_pairs < RANDOM_PAIRS) begin
      if (rand_pairs < RANDOM_PAIRS / 3) begin
        send_idle_pct = 19;
        recv_stall_pct = 52;
      end else if (rand_pairs < 2 * RANDOM_PAIRS / 3) begin
        send_idle_pct = 52;
        recv_stall_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (phase == 2) begin
        // long run so the ramp reaches its end and snaps to the goal
        write_reg(msw_pkg::REG_BYPASS, 16'd0);
        write_reg(msw_pkg::REG_WIDTH, pick_width());
        n = 300;
      end else begin
        if ($urandom_range(99) < 80) write_reg(msw_pkg::REG_WIDTH, pick_width());
        if ($urandom_range(99) < 30) begin
          write_reg(msw_pkg::REG_BYPASS, msw_pkg::WIDTH_BITS'($urandom_range(99) < 30));
        end
        if ($urandom_range(99) < 10) begin
          write_reg(msw_pkg::CFG_INDEX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                    msw_pkg::WIDTH_BITS'($urandom));
        end
        n = $urandom_range(10, 60);
      end
      if (phase == 0 || $urandom_range(99) < 15) begin
        queue_random(n / 2);
        wait_drained();
        queue_random(n - n / 2);
      end else begin
        queue_random(n);
      end
      rand_pairs += n;
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS mid_side_stereo_width");
    end else begin
      $display("FAIL mid_side_stereo_width");
    end
    $finish;
  end

endmodule
